FILE: hdl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the delta timer queue
// Slot count, delay width, operation codes, result codes and the
// command/status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int SLOTS      = 16;
	localparam int DELAY_BITS = 16;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LINK_W     = $clog2(SLOTS + 1);

	localparam int FUNC_W     = 3;
	localparam int SLOT_W     = 4;
	localparam int AMOUNT_W   = 16;
	localparam int STATUS_W   = 2;
	localparam int POPPED_W   = 4;

	// link value meaning end of chain / empty queue
	localparam logic [LINK_W-1:0] NONE = LINK_W'(SLOTS);

	typedef enum logic [FUNC_W-1:0] {
		FN_SCHEDULE    = 3'd0,
		FN_SHIFT       = 3'd1,
		FN_POP         = 3'd2,
		FN_POP_RESCHED = 3'd3,
		FN_REMOVE      = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_QUEUED     = 2'd2,
		ST_NOT_QUEUED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_INS_STEP,
		OP_SHF_STEP,
		OP_REM_STEP,
		OP_REM_ADD,
		OP_POP,
		OP_INS_LINK,
		OP_INS_HEAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    rd_next;
		status_t status;
		logic    push;
	} dtq_cmd_t;

	typedef struct packed {
		logic cur_valid;
		logic fits;
		logic cont;
		logic match;
		logic head_zero;
		logic slot_bad;
		logic slot_queued;
		logic out_free;
	} dtq_stat_t;

endpackage

FILE: hdl/dtq_if.sv
// ----------------------------------------------------------------------------
// dtq_if: request and response channels of the delta timer queue
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface dtq_req_if;
	import dtq_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [SLOT_W-1:0]   slot;
	logic [AMOUNT_W-1:0] amount;

	modport source(output valid, output func, output slot, output amount, input ready);
	modport sink(input valid, input func, input slot, input amount, output ready);
endinterface

interface dtq_rsp_if;
	import dtq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POPPED_W-1:0] popped_slot;

	modport source(output valid, output status, output popped_slot, input ready);
	modport sink(input valid, input status, input popped_slot, output ready);
endinterface

FILE: hdl/delta_timer_queue_top.sv
// ----------------------------------------------------------------------------
// delta_timer_queue_top: delta-list timer queue over a fixed set of slots
// Schedule, shift time, pop expired, pop and reschedule, remove.
// ----------------------------------------------------------------------------
// One request gives one response. Requests are taken one at a time: a new
// request is accepted only once the last one has passed its result to the
// output register. The walk visits one slot per cycle, bounded by the
// single read port of the delay/link memories. The response sits in an
// output register, so the next request is accepted while it waits.
module delta_timer_queue_top (
	input  logic      clk,
	input  logic      arst_n,
	dtq_req_if.sink   req,
	dtq_rsp_if.source rsp
);
	import dtq_pkg::*;

	dtq_cmd_t  cmd;
	dtq_stat_t st;

	dtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_func  (req.func),
		.st       (st),
		.cmd      (cmd)
	);

	dtq_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_slot    (req.slot),
		.in_amount  (req.amount),
		.out_ready  (rsp.ready),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_popped (rsp.popped_slot)
	);

endmodule

FILE: hdl/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl: sequencer of the delta timer queue
// Decodes a request, steps the chain walk and hands the result to the
// output register.
// ----------------------------------------------------------------------------
module dtq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [dtq_pkg::FUNC_W-1:0] in_func,
	input  dtq_pkg::dtq_stat_t        st,
	output dtq_pkg::dtq_cmd_t         cmd
);
	import dtq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ISSUE,
		S_INS_EVAL,
		S_SHF_EVAL,
		S_REM_EVAL,
		S_REM_ADD,
		S_POP_EVAL,
		S_INS_LINK,
		S_INS_HEAD,
		S_FIN
	} state_t;

	state_t state_q, state_d;
	func_t  op_q, op_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		cmd.op      = OP_NONE;
		cmd.rd_next = 1'b0;
		cmd.status  = ST_OK;
		cmd.push    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					op_d   = func_t'(in_func);
					case (func_t'(in_func))
						FN_SCHEDULE: begin
							if (st.slot_bad) begin
								cmd.status = ST_NOT_QUEUED;
								state_d    = S_FIN;
							end else if (st.slot_queued) begin
								cmd.status = ST_QUEUED;
								state_d    = S_FIN;
							end else begin
								state_d = S_ISSUE;
							end
						end
						FN_SHIFT, FN_POP, FN_POP_RESCHED: begin
							state_d = S_ISSUE;
						end
						FN_REMOVE: begin
							if (st.slot_bad || !st.slot_queued) begin
								cmd.status = ST_NOT_QUEUED;
								state_d    = S_FIN;
							end else begin
								state_d = S_ISSUE;
							end
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_ISSUE: begin
				case (op_q)
					FN_SCHEDULE:               state_d = st.cur_valid ? S_INS_EVAL : S_INS_LINK;
					FN_SHIFT:                  state_d = st.cur_valid ? S_SHF_EVAL : S_FIN;
					FN_POP, FN_POP_RESCHED:    state_d = S_POP_EVAL;
					FN_REMOVE:                 state_d = st.cur_valid ? S_REM_EVAL : S_REM_ADD;
					default:                   state_d = S_FIN;
				endcase
			end
			S_INS_EVAL: begin
				cmd.op = OP_INS_STEP;
				if (st.fits && st.cont) begin
					cmd.rd_next = 1'b1;
				end else begin
					state_d = S_INS_LINK;
				end
			end
			S_SHF_EVAL: begin
				cmd.op = OP_SHF_STEP;
				if (st.fits && st.cont) begin
					cmd.rd_next = 1'b1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_REM_EVAL: begin
				cmd.op      = OP_REM_STEP;
				cmd.rd_next = 1'b1;
				if (st.match || !st.cont) begin
					state_d = S_REM_ADD;
				end
			end
			S_REM_ADD: begin
				cmd.op  = OP_REM_ADD;
				state_d = S_FIN;
			end
			S_POP_EVAL: begin
				cmd.op = OP_POP;
				if (st.head_zero && op_q == FN_POP_RESCHED) begin
					op_d    = FN_SCHEDULE;
					state_d = S_ISSUE;
				end else begin
					state_d = S_FIN;
				end
			end
			S_INS_LINK: begin
				cmd.op  = OP_INS_LINK;
				state_d = S_INS_HEAD;
			end
			S_INS_HEAD: begin
				cmd.op  = OP_INS_HEAD;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= FN_SCHEDULE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("accepted transaction did not start");

	a_fin_retires: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && st.out_free |=> state_q == S_IDLE)
		else $error("finished transaction not retired");

endmodule

FILE: hdl/dtq_dpath.sv
// ----------------------------------------------------------------------------
// dtq_dpath: datapath of the delta timer queue
// Delay and link memories, head pointer, queued flags, walk registers
// and the result register.
// ----------------------------------------------------------------------------
module dtq_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dtq_pkg::SLOT_W-1:0]    in_slot,
	input  logic [dtq_pkg::AMOUNT_W-1:0]  in_amount,
	input  logic                          out_ready,
	input  dtq_pkg::dtq_cmd_t             cmd,
	output dtq_pkg::dtq_stat_t            st,
	output logic                          out_valid,
	output logic [dtq_pkg::STATUS_W-1:0]  out_status,
	output logic [dtq_pkg::POPPED_W-1:0]  out_popped
);
	import dtq_pkg::*;

	logic [DELAY_BITS-1:0] delay_mem [SLOTS];
	logic [LINK_W-1:0]     link_mem  [SLOTS];

	logic [DELAY_BITS-1:0] rd_delay_q;
	logic [LINK_W-1:0]     rd_link_q;

	logic [LINK_W-1:0]     cur_q;
	logic [LINK_W-1:0]     prev_q;
	logic [LINK_W-1:0]     guard_q;
	logic [DELAY_BITS-1:0] rem_q;
	logic [DELAY_BITS-1:0] amount_q;
	logic [IDX_W-1:0]      slot_q;
	logic                  found_q;
	status_t               res_status_q;
	logic [POPPED_W-1:0]   res_popped_q;

	logic [LINK_W-1:0]     head_q;
	logic [SLOTS-1:0]      queued_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [POPPED_W-1:0]   out_popped_q;

	logic [IDX_W-1:0]      in_idx;
	logic [IDX_W-1:0]      cur_idx;
	logic [IDX_W-1:0]      prev_idx;
	logic [IDX_W-1:0]      rd_addr;
	logic [LINK_W-1:0]     nx_norm;
	logic [LINK_W-1:0]     cur_norm;
	logic                  prev_valid;
	logic [DELAY_BITS:0]   sum_w;
	logic [DELAY_BITS-1:0] sum_sat;
	logic [DELAY_BITS-1:0] diff_w;

	logic                  dwr_en;
	logic [IDX_W-1:0]      dwr_addr;
	logic [DELAY_BITS-1:0] dwr_data;
	logic                  lwr_en;
	logic [IDX_W-1:0]      lwr_addr;
	logic [LINK_W-1:0]     lwr_data;

	assign in_idx     = IDX_W'(in_slot);
	assign cur_idx    = cur_q[IDX_W-1:0];
	assign prev_idx   = prev_q[IDX_W-1:0];
	assign prev_valid = (prev_q < NONE);
	assign nx_norm    = (rd_link_q < NONE) ? rd_link_q : NONE;
	assign cur_norm   = (cur_q < NONE) ? cur_q : NONE;
	assign sum_w      = {1'b0, rd_delay_q} + {1'b0, rem_q};
	assign sum_sat    = sum_w[DELAY_BITS] ? '1 : sum_w[DELAY_BITS-1:0];
	assign diff_w     = rd_delay_q - rem_q;
	assign rd_addr    = cmd.rd_next ? rd_link_q[IDX_W-1:0] : cur_idx;

	assign st.cur_valid   = (cur_q < NONE);
	assign st.fits        = (rd_delay_q <= rem_q);
	assign st.cont        = (rd_link_q < NONE) && (guard_q < LINK_W'(SLOTS - 1));
	assign st.match       = (cur_q == LINK_W'(slot_q));
	assign st.head_zero   = (cur_q < NONE) && (rd_delay_q == '0);
	assign st.slot_bad    = (32'(in_slot) >= SLOTS);
	assign st.slot_queued = queued_q[in_idx];
	assign st.out_free    = !out_valid_q || out_ready;

	// memory write selection
	always_comb begin
		dwr_en   = 1'b0;
		dwr_addr = cur_idx;
		dwr_data = diff_w;
		lwr_en   = 1'b0;
		lwr_addr = slot_q;
		lwr_data = NONE;
		case (cmd.op)
			OP_INS_STEP: begin
				dwr_en = !st.fits;
			end
			OP_SHF_STEP: begin
				dwr_en   = 1'b1;
				dwr_data = st.fits ? '0 : diff_w;
			end
			OP_REM_STEP: begin
				lwr_en   = st.match && prev_valid;
				lwr_addr = prev_idx;
				lwr_data = nx_norm;
			end
			OP_REM_ADD: begin
				// successor takes the removed delay, if there is one
				dwr_en   = found_q && st.cur_valid;
				dwr_data = sum_sat;
				lwr_en   = 1'b1;
			end
			OP_POP: begin
				lwr_en   = st.head_zero;
				lwr_addr = cur_idx;
			end
			OP_INS_LINK: begin
				dwr_en   = 1'b1;
				dwr_addr = slot_q;
				dwr_data = rem_q;
				lwr_en   = 1'b1;
				lwr_data = cur_norm;
			end
			OP_INS_HEAD: begin
				lwr_en   = prev_valid;
				lwr_addr = prev_idx;
				lwr_data = LINK_W'(slot_q);
			end
			default: begin
				dwr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dwr_en) begin
			delay_mem[dwr_addr] <= dwr_data;
		end
		if (lwr_en) begin
			link_mem[lwr_addr] <= lwr_data;
		end
		rd_delay_q <= delay_mem[rd_addr];
		rd_link_q  <= link_mem[rd_addr];
	end

	// walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cur_q        <= head_q;
				prev_q       <= NONE;
				rem_q        <= DELAY_BITS'(in_amount);
				amount_q     <= DELAY_BITS'(in_amount);
				guard_q      <= '0;
				slot_q       <= in_idx;
				found_q      <= 1'b0;
				res_status_q <= cmd.status;
				res_popped_q <= '0;
			end
			OP_INS_STEP, OP_SHF_STEP: begin
				if (st.fits) begin
					rem_q   <= rem_q - rd_delay_q;
					prev_q  <= cur_q;
					cur_q   <= rd_link_q;
					guard_q <= guard_q + LINK_W'(1);
				end
			end
			OP_REM_STEP: begin
				if (st.match) begin
					cur_q   <= nx_norm;
					rem_q   <= rd_delay_q;
					found_q <= 1'b1;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= rd_link_q;
					guard_q <= guard_q + LINK_W'(1);
				end
			end
			OP_POP: begin
				if (st.head_zero) begin
					res_popped_q <= POPPED_W'(cur_q);
					slot_q       <= cur_idx;
					cur_q        <= nx_norm;
					prev_q       <= NONE;
					rem_q        <= amount_q;
					guard_q      <= '0;
				end else begin
					res_status_q <= ST_EMPTY;
				end
			end
			default: begin
				found_q <= found_q;
			end
		endcase
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_popped_q <= res_popped_q;
		end
	end

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= NONE;
			queued_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_REM_STEP: begin
					if (st.match && !prev_valid) begin
						head_q <= nx_norm;
					end
				end
				OP_REM_ADD: begin
					queued_q[slot_q] <= 1'b0;
				end
				OP_POP: begin
					if (st.head_zero) begin
						head_q            <= nx_norm;
						queued_q[cur_idx] <= 1'b0;
					end
				end
				OP_INS_LINK: begin
					queued_q[slot_q] <= 1'b1;
				end
				OP_INS_HEAD: begin
					if (!prev_valid) begin
						head_q <= LINK_W'(slot_q);
					end
				end
				default: begin
					head_q <= head_q;
				end
			endcase
			out_valid_q <= cmd.push || (out_valid_q && !out_ready);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_popped = out_popped_q;

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NONE)
		else $error("head pointer out of range");

	a_insert_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_INS_LINK |=> queued_q[$past(slot_q)])
		else $error("inserted slot not marked queued");

	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_POP && st.head_zero |=> !queued_q[$past(cur_idx)])
		else $error("popped slot still marked queued");

endmodule
